// ===== hw/rtl/siwl_pkg.sv =====
// Package with the shared types and constants of the sorted interval wait lookup.
package siwl_pkg;

	// Field widths.
	localparam int TIME_W = 31;
	localparam int WAIT_W = 32;

	// Action codes.
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	// Answer when no interval ends after the query time.
	localparam logic [WAIT_W-1:0] WAIT_NONE = '1;

	// Data one cell hands to the next one for an ordered insert.
	typedef struct packed {
		logic              greater;
		logic [TIME_W-1:0] ival_start;
		logic [TIME_W-1:0] ival_end;
	} link_t;

	// Query token that walks down the row, one cell per cycle.
	typedef struct packed {
		logic              found;
		logic [TIME_W-1:0] wait_val;
	} tok_t;

endpackage

// ===== hw/rtl/siwl_cell.sv =====
// One cell of the interval row: holds one interval, inserts in order and checks query tokens.
module siwl_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid,
	input  logic                         at_tail,
	input  logic                         ins_en,
	input  logic [siwl_pkg::TIME_W-1:0] ins_start,
	input  logic [siwl_pkg::TIME_W-1:0] ins_end,
	input  logic [siwl_pkg::TIME_W-1:0] qtime,
	input  siwl_pkg::link_t              link_in,
	output siwl_pkg::link_t              link_out,
	input  siwl_pkg::tok_t               tok_in,
	output siwl_pkg::tok_t               tok_out
);
	import siwl_pkg::*;

	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] end_q;
	logic              greater;
	logic              take;
	logic              hit;
	tok_t              tok_q;
	tok_t              tok_d;

	// A stored start above the new one means this entry moves one place down.
	assign greater = valid && (start_q > ins_start);
	assign take    = ins_en && (greater || at_tail);

	assign link_out.greater    = greater;
	assign link_out.ival_start = start_q;
	assign link_out.ival_end   = end_q;

	// Take the neighbor's entry when it moves too, else the new interval.
	always_ff @(posedge clk) begin
		if (take) begin
			if (link_in.greater) begin
				start_q <= link_in.ival_start;
				end_q   <= link_in.ival_end;
			end else begin
				start_q <= ins_start;
				end_q   <= ins_end;
			end
		end
	end

	// The first valid entry whose end lies after the query time answers.
	assign hit = valid && (qtime < end_q);

	always_comb begin
		tok_d = tok_in;
		if (!tok_in.found && hit) begin
			tok_d.found = 1'b1;
			if (qtime >= start_q) begin
				tok_d.wait_val = '0;
			end else begin
				tok_d.wait_val = start_q - qtime;
			end
		end
	end

	// Token stage register toward the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hw/rtl/sorted_interval_wait_lookup.sv =====
// Top level of the sorted interval wait lookup: cell row, count, query sequencing and result.
//
// The table is a row of TABLE_DEPTH cells kept in ascending order of start. A clear or a
// load item is done in the cycle after it is accepted: done pulses for one cycle in the
// next cycle and busy stays low, so these items can be given every cycle. A query item
// walks down the row one cell per cycle, and its answer shows on done once the token
// has passed the last cell; busy is high from the accept until the answer shows. The
// result is shown for one cycle only and must be taken then. A load into a full table
// leaves the table as it is and reports status 1.
module sorted_interval_wait_lookup #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   action,
	input  logic [siwl_pkg::TIME_W-1:0] interval_start,
	input  logic [siwl_pkg::TIME_W-1:0] interval_end,
	input  logic [siwl_pkg::TIME_W-1:0] query_time,
	output logic                         done,
	output logic signed [siwl_pkg::WAIT_W-1:0] wait_time,
	output logic                         status
);
	import siwl_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WAIT_W-1:0] wait_q;
	logic              status_q;
	logic [TIME_W-1:0] qtime_q;
	logic              accept;
	logic              full;
	logic              ins_en;
	logic              query_end;

	link_t link [TABLE_DEPTH+1];
	tok_t  tok  [TABLE_DEPTH+1];

	assign accept    = start && !busy_q;
	assign full      = (count_q == CW'(TABLE_DEPTH));
	assign ins_en    = accept && (action == ACT_LOAD) && !full;
	assign query_end = busy_q && (cnt_q == CW'(TABLE_DEPTH));

	assign link[0] = '0;
	assign tok[0]  = '0;

	// Row of cells.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		siwl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid     (CW'(i) < count_q),
			.at_tail   (CW'(i) == count_q),
			.ins_en    (ins_en),
			.ins_start (interval_start),
			.ins_end   (interval_end),
			.qtime     (qtime_q),
			.link_in   (link[i]),
			.link_out  (link[i+1]),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1])
		);
	end

	// Query time stays put while the token walks the row.
	always_ff @(posedge clk) begin
		if (accept && (action == ACT_QUERY)) begin
			qtime_q <= query_time;
		end
	end

	// Entry count, query sequencing and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cnt_q    <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			wait_q   <= '0;
			status_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				wait_q   <= '0;
				status_q <= 1'b0;
				case (action)
					ACT_CLEAR: begin
						count_q <= '0;
						done_q  <= 1'b1;
					end
					ACT_LOAD: begin
						if (full) begin
							status_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
						done_q <= 1'b1;
					end
					ACT_QUERY: begin
						busy_q <= 1'b1;
						cnt_q  <= '0;
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end else if (query_end) begin
				busy_q   <= 1'b0;
				done_q   <= 1'b1;
				status_q <= 1'b0;
				wait_q   <= tok[TABLE_DEPTH].found ?
					{1'b0, tok[TABLE_DEPTH].wait_val} : WAIT_NONE;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign wait_time = wait_q;
	assign status    = status_q;

	// The count never passes the table depth.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// An accepted query makes the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (action == ACT_QUERY) |=> busy_q && !done_q)
		else $error("query accepted without busy");

	// A dropped load never carries a wait value.
	assert property (@(posedge clk) disable iff (!arst_n) done_q && status_q |-> wait_q == '0)
		else $error("dropped load with nonzero wait");

	// The table does not change while a query walks the row.
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |=> $stable(count_q))
		else $error("table count changed during a query");

endmodule
